// ===== design/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// ale_pkg: shared types and helpers for the associated legendre evaluator
// working value types, saturation, sequencer states and divider interface
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

   localparam int ValW = 53;
   localparam int NumW = 60;
   localparam int DivW = 59;

   typedef logic signed [ValW-1:0] val_type;
   typedef logic signed [NumW-1:0] num_type;

   localparam num_type NUM_VAL_MAX = (num_type'(1) <<< 52) - num_type'(1);
   localparam num_type NUM_VAL_MIN = -(num_type'(1) <<< 52);

   typedef enum logic [2:0] {
      PH_SEED  = 3'b001,
      PH_FIRST = 3'b010,
      PH_REC   = 3'b100
   } phase_type;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_RAD    = 11'b000_0000_0010,
      S_SQRT   = 11'b000_0000_0100,
      S_SRND   = 11'b000_0000_1000,
      S_PLAN   = 11'b000_0001_0000,
      S_MUL_LO = 11'b000_0010_0000,
      S_MUL_HI = 11'b000_0100_0000,
      S_RND    = 11'b000_1000_0000,
      S_COEF   = 11'b001_0000_0000,
      S_DIVGO  = 11'b010_0000_0000,
      S_DIV    = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic            start;
      logic [DivW-1:0] dividend;
      logic [3:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [DivW-1:0] quotient;
   } div_sts_type;

   function automatic val_type sat53(input num_type n);
      val_type r;
      if (n > NUM_VAL_MAX) begin
         r = val_type'(NUM_VAL_MAX);
      end else if (n < NUM_VAL_MIN) begin
         r = val_type'(NUM_VAL_MIN);
      end else begin
         r = val_type'(n);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/ale_div.sv =====
// ----------------------------------------------------------------------------
// ale_div: bit-serial restoring divider
// unsigned dividend by a small divisor, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ale_div
   import ale_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_sts_type      div_sts
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DivW-1:0] quo_ff, quo_in;
   logic [3:0]      rem_ff, rem_in;
   logic [3:0]      dsr_ff, dsr_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [4:0]      rem_sh;
   logic            ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DivW-1]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = 6'(DivW);
      end else if (busy_ff) begin
         rem_in = ge ? 4'(rem_sh - {1'b0, dsr_ff}) : rem_sh[3:0];
         quo_in = {quo_ff[DivW-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign div_sts.busy     = busy_ff;
   assign div_sts.done     = done_ff;
   assign div_sts.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/associated_legendre_evaluator_top.sv =====
// flow: a rejected item returns its beat through the done and output registers;
// otherwise the root of 1-x^2 is taken when m != 0, the m seed products follow,
// and when l > m the first product and the upward recurrence run; the pace is
// set by the 2-bit-per-cycle square root, the shared 32x32 multiplier used twice
// per product and the serial divider in each recurrence step.
// throughput: one item at a time; reset: synchronous, active high, clears sequencer.
// ----------------------------------------------------------------------------
// associated_legendre_evaluator_top: associated legendre polynomial evaluator
// computes P_l^|m|(x) by seed product and upward recurrence on a shared unit
// ----------------------------------------------------------------------------
`default_nettype none

module associated_legendre_evaluator_top
   import ale_pkg::*;
#(
   parameter int MAX_DEGREE    = 7,
   parameter int OUT_FRAC_BITS = 32
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_degree,
   input  wire logic signed [3:0]  req_order,
   input  wire logic signed [31:0] req_argument,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [52:0]      rsp_value,
   output logic                    rsp_invalid
);

   localparam val_type ONE_VAL = val_type'(1) <<< OUT_FRAC_BITS;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [2:0]  l_ff, l_in;
   logic [3:0]  m_ff, m_in;
   logic signed [31:0] x_ff, x_in;
   logic [30:0] ux_ff, ux_in;
   logic [30:0] s_ff, s_in;
   logic [61:0] rad_ff, rad_in;
   logic [34:0] srem_ff, srem_in;
   logic [30:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [3:0]  step_ff, step_in;
   val_type     pmm_ff, pmm_in;
   val_type     pm1m_ff, pm1m_in;
   val_type     mr_ff, mr_in;
   num_type     num_ff, num_in;
   logic [62:0] lo_ff, lo_in;
   logic [51:0] hi_ff, hi_in;
   logic        done_ff, done_in;
   val_type     res_ff, res_in;
   logic        inv_ff, inv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   val_type     rsp_value_ff, rsp_value_in;
   logic        rsp_invalid_ff, rsp_invalid_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   val_type     op_v;
   logic [52:0] uv;
   logic [30:0] ut;
   logic        neg;
   logic [34:0] rem_sh, trial;
   logic        sq_ge;
   logic [85:0] full;
   logic [55:0] rnd;
   logic [53:0] capped;
   logic [3:0]  m_mag;
   logic        bad;
   logic        accept;
   logic [4:0]  nstep;
   num_type     coef_a, coef_b;
   logic [DivW-1:0] num_mag;
   num_type     qs;
   val_type     next_v;
   div_req_type div_req;
   div_sts_type div_sts;

   ale_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   assign accept = req_valid && !req_stall;
   assign m_mag  = req_order[3] ? 4'(-req_order) : 4'(req_order);
   assign bad    = (m_mag > {1'b0, req_degree}) || (4'(req_degree) > 4'(MAX_DEGREE))
                   || (req_argument > 32'sh4000_0000) || (req_argument < -32'sh4000_0000);

   // operands of the shared multiplier
   always_comb begin
      op_v = (phase_ff == PH_REC) ? pm1m_ff : pmm_ff;
      uv   = op_v[52] ? 53'(-op_v) : 53'(op_v);
      ut   = (phase_ff == PH_SEED) ? s_ff : ux_ff;
      neg  = op_v[52] ^ ((phase_ff != PH_SEED) && x_ff[31]);
      case (state_ff)
         S_RAD: begin
            mul_a = 32'(ux_ff);
            mul_b = 32'(ux_ff);
         end
         S_MUL_HI: begin
            mul_a = 32'(uv[52:32]);
            mul_b = 32'(ut);
         end
         default: begin
            mul_a = uv[31:0];
            mul_b = 32'(ut);
         end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      rem_sh = {srem_ff[32:0], rad_ff[61:60]};
      trial  = {2'b00, root_ff, 2'b01};
      sq_ge  = rem_sh >= trial;
      full   = 86'({hi_ff, 32'b0}) + 86'(lo_ff) + (86'(1) << 29);
      rnd    = full[85:30];
      capped = (rnd > (56'(1) << 52)) ? (54'(1) << 52) : rnd[53:0];
      num_mag = num_ff[NumW-1] ? DivW'(-num_ff) : DivW'(num_ff);
      qs      = num_ff[NumW-1] ? -num_type'(div_sts.quotient) : num_type'(div_sts.quotient);
      next_v  = sat53(qs);
      nstep   = 5'(step_ff) + 5'd1;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      l_in     = l_ff;
      m_in     = m_ff;
      x_in     = x_ff;
      ux_in    = ux_ff;
      s_in     = s_ff;
      rad_in   = rad_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      pmm_in   = pmm_ff;
      pm1m_in  = pm1m_ff;
      mr_in    = mr_ff;
      num_in   = num_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      inv_in   = inv_ff;
      coef_a   = '0;
      coef_b   = '0;
      div_req.start    = 1'b0;
      div_req.dividend = num_mag + DivW'(4'(nstep) - m_ff >> 1);
      div_req.divisor  = step_ff - m_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               l_in   = req_degree;
               m_in   = m_mag;
               x_in   = req_argument;
               ux_in  = req_argument[31] ? 31'(-req_argument) : 31'(req_argument);
               pmm_in = ONE_VAL;
               step_in = 4'd1;
               phase_in = PH_SEED;
               if (bad) begin
                  res_in  = '0;
                  inv_in  = 1'b1;
                  done_in = 1'b1;
               end else if (m_mag != 4'd0) begin
                  state_in = S_RAD;
               end else begin
                  state_in = S_PLAN;
               end
            end
         end
         S_RAD: begin
            rad_in   = (62'(1) << 60) - 62'(mul_p);
            srem_in  = '0;
            root_in  = '0;
            cnt_in   = 5'd31;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            srem_in = sq_ge ? rem_sh - trial : rem_sh;
            root_in = {root_ff[29:0], sq_ge};
            rad_in  = {rad_ff[59:0], 2'b00};
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = S_SRND;
            end
         end
         S_SRND: begin
            s_in     = (srem_ff > 35'(root_ff)) ? root_ff + 31'd1 : root_ff;
            state_in = S_MUL_LO;
         end
         S_PLAN: begin
            if (m_ff < {1'b0, l_ff}) begin
               phase_in = PH_FIRST;
               state_in = S_MUL_LO;
            end else begin
               res_in   = pmm_ff;
               inv_in   = 1'b0;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MUL_LO: begin
            lo_in    = mul_p[62:0];
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            hi_in    = mul_p[51:0];
            state_in = S_RND;
         end
         S_RND: begin
            mr_in    = sat53(neg ? -num_type'(capped) : num_type'(capped));
            state_in = S_COEF;
         end
         S_COEF: begin
            case (phase_ff)
               PH_SEED: begin
                  coef_a = -num_type'({step_ff, 1'b0} - 5'd1);
                  pmm_in = sat53(coef_a * num_type'(mr_ff));
                  if (step_ff == m_ff) begin
                     state_in = S_PLAN;
                  end else begin
                     step_in  = step_ff + 4'd1;
                     state_in = S_MUL_LO;
                  end
               end
               PH_FIRST: begin
                  coef_a  = num_type'({m_ff, 1'b1});
                  pm1m_in = sat53(coef_a * num_type'(mr_ff));
                  step_in = m_ff + 4'd2;
                  if ((5'(m_ff) + 5'd2) <= 5'(l_ff)) begin
                     phase_in = PH_REC;
                     state_in = S_MUL_LO;
                  end else begin
                     res_in   = sat53(coef_a * num_type'(mr_ff));
                     inv_in   = 1'b0;
                     done_in  = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  coef_a   = num_type'({step_ff, 1'b0} - 5'd1);
                  coef_b   = num_type'(5'(step_ff) + 5'(m_ff) - 5'd1);
                  num_in   = coef_a * num_type'(mr_ff) - coef_b * num_type'(pmm_ff);
                  state_in = S_DIVGO;
               end
            endcase
         end
         S_DIVGO: begin
            // rounding half of the divisor is folded into the dividend
            div_req.start    = 1'b1;
            div_req.dividend = num_mag + DivW'((step_ff - m_ff) >> 1);
            state_in         = S_DIV;
         end
         S_DIV: begin
            if (div_sts.done) begin
               pmm_in  = pm1m_ff;
               pm1m_in = next_v;
               step_in = step_ff + 4'd1;
               if (nstep <= 5'(l_ff)) begin
                  state_in = S_MUL_LO;
               end else begin
                  res_in   = next_v;
                  inv_in   = 1'b0;
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result waits in the output register; sequencer only restarts from idle
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_value_in   = rsp_value_ff;
      rsp_invalid_in = rsp_invalid_ff;
      if (done_ff) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = res_ff;
         rsp_invalid_in = inv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff       <= phase_in;
      l_ff           <= l_in;
      m_ff           <= m_in;
      x_ff           <= x_in;
      ux_ff          <= ux_in;
      s_ff           <= s_in;
      rad_ff         <= rad_in;
      srem_ff        <= srem_in;
      root_ff        <= root_in;
      cnt_ff         <= cnt_in;
      step_ff        <= step_in;
      pmm_ff         <= pmm_in;
      pm1m_ff        <= pm1m_in;
      mr_ff          <= mr_in;
      num_ff         <= num_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      res_ff         <= res_in;
      inv_ff         <= inv_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   // a beat must be free before the sequencer may finish another item
   assign req_stall   = (state_ff != S_IDLE) || done_ff || (rsp_valid_ff && rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_invalid = rsp_invalid_ff;

   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_value == '0)
      else $error("invalid beat carries a nonzero value");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("accepted item did not make the block busy");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == S_DIV)
      else $error("divider finished outside its wait state");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL_LO && phase_ff == PH_SEED |-> s_ff <= 31'h4000_0000)
      else $error("root of 1-x^2 above one");

endmodule

`default_nettype wire

// ===== bench/associated_legendre_evaluator_top_test.sv =====
// ----------------------------------------------------------------------------
// associated_legendre_evaluator_top_test: self-checking bench for the evaluator
// drives degree/order/argument beats with random gaps, predicts P_l^|m|(x) and
// the invalid flag, and checks each result beat in order under random stalls
// ----------------------------------------------------------------------------
`default_nettype none

module associated_legendre_evaluator_top_test;
   import ale_pkg::*;

   localparam int MaxDeg     = 7;
   localparam int OutFrac    = 32;
   localparam longint ValMax = (64'sd1 <<< 52) - 1;
   localparam longint ValMin = -(64'sd1 <<< 52);
   localparam longint OneQ30 = 64'sd1 <<< 30;
   localparam int CycleLimit = 3000000;

   typedef struct packed {
      logic signed [52:0] value;
      logic               invalid;
   } legendre_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_degree;
   logic signed [3:0]  req_order;
   logic signed [31:0] req_argument;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [52:0] rsp_value;
   logic               rsp_invalid;

   legendre_type expected_q[$];
   int           error_count;
   int           cycle_count;
   logic         stall_free;

   associated_legendre_evaluator_top #(
      .MAX_DEGREE   (MaxDeg),
      .OUT_FRAC_BITS(OutFrac)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_degree  (req_degree),
      .req_order   (req_order),
      .req_argument(req_argument),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_value   (rsp_value),
      .rsp_invalid (rsp_invalid)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint clamp53(input longint v);
      if (v > ValMax) return ValMax;
      if (v < ValMin) return ValMin;
      return v;
   endfunction

   function automatic longint abs64(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // product scaled down by 2^30, rounded, ties away from zero
   function automatic longint scale_q30(input longint v, input longint t);
      longint uv, ut, hi, lo, r;
      uv = abs64(v);
      ut = abs64(t);
      hi = uv >>> 32;
      lo = uv & 64'hFFFF_FFFF;
      r  = ((hi * ut) <<< 2) + ((lo * ut + (64'sd1 <<< 29)) >>> 30);
      if (r > ValMax + 1) r = ValMax + 1;
      return clamp53(((v < 0) != (t < 0)) ? -r : r);
   endfunction

   function automatic longint root_round(input longint v);
      longint res, bit_w;
      res   = 0;
      bit_w = 64'sd1 <<< 62;
      while (bit_w > v) bit_w = bit_w >>> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v   = v - (res + bit_w);
            res = (res >>> 1) + bit_w;
         end else begin
            res = res >>> 1;
         end
         bit_w = bit_w >>> 2;
      end
      if (v > res) res++;
      return res;
   endfunction

   function automatic legendre_type legendre_value(input logic [2:0] deg,
                                                   input logic signed [3:0] ord,
                                                   input logic signed [31:0] arg);
      legendre_type r;
      longint l, m, x, s, pmm, pm1m, num, nxt, q;
      l = deg;
      m = abs64(longint'(ord));
      x = arg;
      r.invalid = 1'b0;
      r.value   = '0;
      if (m > l || l > MaxDeg || x > OneQ30 || x < -OneQ30) begin
         r.invalid = 1'b1;
         return r;
      end
      pmm = 64'sd1 <<< OutFrac;
      if (m > 0) begin
         s = root_round((64'sd1 <<< 60) - x * x);
         for (longint j = 1; j <= m; j++) pmm = clamp53(-(2 * j - 1) * scale_q30(pmm, s));
      end
      if (l > m) begin
         pm1m = clamp53((2 * m + 1) * scale_q30(pmm, x));
         for (longint k = m + 2; k <= l; k++) begin
            num = (2 * k - 1) * scale_q30(pm1m, x) - (k + m - 1) * pmm;
            q   = (abs64(num) + (k - m) / 2) / (k - m);
            nxt = clamp53((num < 0) ? -q : q);
            pmm  = pm1m;
            pm1m = nxt;
         end
         pmm = pm1m;
      end
      r.value = pmm[52:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   // valid stays high across a zero gap, otherwise drops until the random gap has passed
   task automatic send_beat(input logic [2:0] deg, input logic signed [3:0] ord,
                            input logic signed [31:0] arg);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_degree   <= deg;
      req_order    <= ord;
      req_argument <= arg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(legendre_value(deg, ord, arg));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      legendre_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_value !== exp_r.value)
               report_mismatch($sformatf("value %0d expected %0d", rsp_value, exp_r.value));
            if (rsp_invalid !== exp_r.invalid)
               report_mismatch($sformatf("invalid %b expected %b", rsp_invalid,
                                         exp_r.invalid));
         end
      end
   end

   // receiver stall pattern
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_free) begin
            rsp_stall <= 1'b0;
         end else begin
            hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if (hold != 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic test_extremes();
      logic signed [31:0] args[5];
      args = '{-32'sd1073741824, 32'sd1073741824, 32'sd0, 32'sd536870912, -32'sd1};
      for (int l = 0; l <= 7; l++) send_beat(3'(l), 4'(l), args[l % 5]);
      send_beat(3'd7, -4'sd7, 32'sd1073741824);
      send_beat(3'd7, 4'sd0, -32'sd1073741824);
      send_beat(3'd7, 4'sd3, 32'sd700000000);
      send_beat(3'd5, 4'sd1, -32'sd900000000);
   endtask

   task automatic test_rejects();
      send_beat(3'd2, 4'sd3, 32'sd0);                 // order above degree
      send_beat(3'd7, 4'sh8, 32'sd100);               // most negative order
      send_beat(3'd4, 4'sd1, 32'sd1073741825);        // argument just above one
      send_beat(3'd4, -4'sd2, -32'sd1073741825);
      send_beat(3'd0, 4'sd0, 32'h7FFF_FFFF);
      send_beat(3'd0, 4'sd0, 32'h8000_0000);
      send_beat(3'd0, -4'sd1, 32'sd5);
   endtask

   task automatic test_random(input int count);
      logic signed [31:0] arg;
      logic [2:0]         deg;
      logic signed [3:0]  ord;
      for (int n = 0; n < count; n++) begin
         // keep long recurrences rare so the run stays short
         deg = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         ord = 4'($urandom_range(0, deg));
         if ($urandom_range(0, 1)) ord = -ord;
         arg = 32'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
         case ($urandom_range(0, 9))
            0: ord = 4'($urandom);
            1: arg = 32'($urandom);
            2: arg = $urandom_range(0, 1) ? 32'sd1073741824 : -32'sd1073741824;
            default: arg = 32'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
         endcase
         if (ord == 4'sh0 || $urandom_range(0, 9) != 1) begin
            if (arg > 32'sd1073741824 || arg < -32'sd1073741824)
               arg = $urandom_range(0, 9) == 0 ? arg : arg >>> 2;
         end
         send_beat(deg, ord, arg);
         if (n == count / 2) wait_drained();
      end
   endtask

   initial begin
      error_count  = 0;
      cycle_count  = 0;
      stall_free   = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_degree   = '0;
      req_order    = '0;
      req_argument = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_rejects();
      test_random(300);
      stall_free = 1'b1;
      test_random(100);
      stall_free = 1'b0;
      test_random(300);
      wait_drained();
      repeat (500) @(negedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
